FILE: design/sstq_pkg.sv
// Shared constants, codes and helpers for the sorted timer queue.
`timescale 1ns / 1ps
package sstq_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int OP_W     = 2;
  localparam int DELAY_W  = 32;
  localparam int KEY_W    = 16;
  localparam int ID_W     = 16;
  localparam int KIND_W   = 2;
  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 31;
  localparam int TPER_W   = 10;
  localparam int APB_AW   = 2;
  localparam int APB_DW   = 32;

  localparam logic [TPER_W-1:0]   TPER_RESET = 10'd10;
  localparam logic [TICK_W-1:0]   SIGN_BIT   = 32'h8000_0000;
  localparam logic [PERIOD_W-1:0] TICK_MAX   = 31'h7FFF_FFFF;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_REG    = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_REG    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd2;

  function automatic logic not_before(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] d;
    d = a - b;
    return (d & SIGN_BIT) == '0;
  endfunction

endpackage

FILE: design/sstq_ifs.sv
// Valid/ready channel interfaces for the timer queue requests and results.
`timescale 1ns / 1ps
interface sstq_req_if;
  logic                         valid;
  logic                         ready;
  logic [sstq_pkg::OP_W-1:0]    op;
  logic [sstq_pkg::DELAY_W-1:0] delay_ms;
  logic                         repeat_req;
  logic [sstq_pkg::KEY_W-1:0]   callback_key;
  logic [sstq_pkg::ID_W-1:0]    cancel_id;
  modport source (output valid, op, delay_ms, repeat_req, callback_key, cancel_id,
                  input ready);
  modport sink (input valid, op, delay_ms, repeat_req, callback_key, cancel_id,
                output ready);
endinterface

interface sstq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sstq_pkg::KIND_W-1:0] kind;
  logic [sstq_pkg::ID_W-1:0]   timer_id;
  logic                        found;
  logic [sstq_pkg::KEY_W-1:0]  fired_key;
  logic                        last;
  modport source (output valid, kind, timer_id, found, fired_key, last, input ready);
  modport sink (input valid, kind, timer_id, found, fired_key, last, output ready);
endinterface

FILE: design/sorted_software_timer_queue_core.sv
// Sorted timer queue core: a sequencer over a due-ordered timer table.
// One transaction is handled at a time; req.ready is low while it is at work. A register
// does a bit-serial division of the delay by tick_period_ms, forms the due tick, scans the
// table slots to find its place, then checks every slot for each id candidate tried. A
// cancel searches the table slots for its id. A tick passes each fired timer through S_FIRE
// and S_CHECK, scans the table to re-insert a periodic one, and waits for each result to
// be taken. At most 16 timers fire per tick.
`timescale 1ns / 1ps
module sorted_software_timer_queue_core #(
  parameter int TABLE_DEPTH = sstq_pkg::TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  sstq_req_if.sink                      req,
  sstq_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sstq_pkg::APB_AW-1:0]   paddr,
  input  logic [sstq_pkg::APB_DW-1:0]   pwdata,
  output logic [sstq_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sstq_pkg::MAX_RESULTS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DIV    = 10'b00_0000_0010,
    S_DUE    = 10'b00_0000_0100,
    S_POS    = 10'b00_0000_1000,
    S_UNIQ   = 10'b00_0001_0000,
    S_CANCEL = 10'b00_0010_0000,
    S_FIRE   = 10'b00_0100_0000,
    S_REINS  = 10'b00_1000_0000,
    S_CHECK  = 10'b01_0000_0000,
    S_WAIT   = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic [sstq_pkg::ID_W-1:0]     ent_id     [TABLE_DEPTH];
  logic [sstq_pkg::KEY_W-1:0]    ent_key    [TABLE_DEPTH];
  logic [sstq_pkg::TICK_W-1:0]   ent_due    [TABLE_DEPTH];
  logic [sstq_pkg::PERIOD_W-1:0] ent_period [TABLE_DEPTH];

  logic [sstq_pkg::TPER_W-1:0]   tick_period;
  logic [sstq_pkg::TICK_W-1:0]   tick_count;

  logic [IDX_W-1:0]              idx;
  logic [4:0]                    bit_cnt;
  logic [sstq_pkg::DELAY_W-1:0]  quo;
  logic [sstq_pkg::TPER_W-1:0]   rem;
  logic [sstq_pkg::TPER_W-1:0]   divisor;
  logic [sstq_pkg::PERIOD_W-1:0] ticks;
  logic [sstq_pkg::TICK_W-1:0]   new_due;
  logic [sstq_pkg::ID_W-1:0]     cand;
  logic [sstq_pkg::KEY_W-1:0]    new_key;
  logic                          new_rep;
  logic [sstq_pkg::PERIOD_W-1:0] new_per;
  logic [sstq_pkg::ID_W-1:0]     cancel_id;
  logic [CNT_W-1:0]              fire_cnt;
  logic                          have_cur;

  logic                          o_valid;
  logic [sstq_pkg::KIND_W-1:0]   o_kind;
  logic [sstq_pkg::ID_W-1:0]     o_id;
  logic                          o_found;
  logic [sstq_pkg::KEY_W-1:0]    o_key;
  logic                          o_last;

  logic                          in_acc;
  logic                          out_acc;
  logic [sstq_pkg::TPER_W:0]     rem_sh;
  logic [sstq_pkg::TPER_W:0]     div_ext;
  logic [sstq_pkg::PERIOD_W-1:0] ticks_c;
  logic [sstq_pkg::ID_W-1:0]     cand_inc;
  logic                          cont;

  assign req.ready     = (state == S_IDLE) && !o_valid;
  assign in_acc        = req.valid && req.ready;
  assign out_acc       = o_valid && rsp.ready;
  assign rsp.valid     = o_valid;
  assign rsp.kind      = o_kind;
  assign rsp.timer_id  = o_id;
  assign rsp.found     = o_found;
  assign rsp.fired_key = o_key;
  assign rsp.last      = o_last;

  assign pready = 1'b1;
  assign prdata = {{(sstq_pkg::APB_DW - sstq_pkg::TPER_W){1'b0}}, tick_period};

  always_comb begin
    div_ext = {1'b0, divisor};
    rem_sh  = {rem, quo[sstq_pkg::DELAY_W-1]};
    if (quo[sstq_pkg::DELAY_W-1]) begin
      ticks_c = sstq_pkg::TICK_MAX;
    end else if (quo == '0) begin
      ticks_c = sstq_pkg::PERIOD_W'(1);
    end else begin
      ticks_c = quo[sstq_pkg::PERIOD_W-1:0];
    end
    cand_inc = cand + sstq_pkg::ID_W'(1);
    if (cand_inc == '0) begin
      cand_inc = sstq_pkg::ID_W'(1);
    end
    cont = (fire_cnt != CNT_W'(sstq_pkg::MAX_RESULTS)) && (ent_id[0] != '0) &&
           sstq_pkg::not_before(tick_count, ent_due[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= sstq_pkg::TPER_RESET;
    end else if (psel && penable && pwrite && pready && paddr == '0) begin
      tick_period <= pwdata[sstq_pkg::TPER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      o_valid    <= 1'b0;
      tick_count <= '0;
      have_cur   <= 1'b0;
      fire_cnt   <= '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        ent_id[k] <= '0;
      end
    end else begin
      if (out_acc) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (req.op)
              sstq_pkg::OP_TICK: begin
                tick_count <= tick_count + sstq_pkg::TICK_W'(1);
                fire_cnt   <= '0;
                have_cur   <= 1'b0;
                state      <= S_CHECK;
              end
              sstq_pkg::OP_REG: begin
                if (ent_id[TABLE_DEPTH-1] != '0) begin
                  o_valid <= 1'b1;
                  o_kind  <= sstq_pkg::KIND_REG;
                  o_id    <= '0;
                  o_found <= 1'b0;
                  o_key   <= '0;
                  o_last  <= 1'b1;
                end else begin
                  quo     <= req.delay_ms;
                  rem     <= '0;
                  divisor <= (tick_period == '0) ? sstq_pkg::TPER_W'(1) : tick_period;
                  bit_cnt <= '0;
                  new_key <= req.callback_key;
                  new_rep <= req.repeat_req;
                  state   <= S_DIV;
                end
              end
              sstq_pkg::OP_CANCEL: begin
                cancel_id <= req.cancel_id;
                idx       <= '0;
                if (req.cancel_id == '0) begin
                  o_valid <= 1'b1;
                  o_kind  <= sstq_pkg::KIND_CANCEL;
                  o_id    <= req.cancel_id;
                  o_found <= 1'b0;
                  o_key   <= '0;
                  o_last  <= 1'b1;
                end else begin
                  state <= S_CANCEL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (rem_sh >= div_ext) begin
            rem <= sstq_pkg::TPER_W'(rem_sh - div_ext);
            quo <= {quo[sstq_pkg::DELAY_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[sstq_pkg::TPER_W-1:0];
            quo <= {quo[sstq_pkg::DELAY_W-2:0], 1'b0};
          end
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'd31) begin
            state <= S_DUE;
          end
        end
        S_DUE: begin
          ticks   <= ticks_c;
          new_due <= tick_count + {1'b0, ticks_c};
          cand    <= sstq_pkg::ID_W'(1);
          idx     <= '0;
          state   <= S_POS;
        end
        S_POS: begin
          if (idx != IDX_LAST && ent_id[idx] != '0 &&
              sstq_pkg::not_before(new_due, ent_due[idx])) begin
            cand <= ent_id[idx];
            idx  <= idx + IDX_W'(1);
          end else begin
            new_per <= new_rep ? ticks : '0;
            bit_cnt <= '0;
            state   <= S_UNIQ;
            // hold insert position in idx; scan ids with bit_cnt-free slot counter below
            cancel_id <= '0;
          end
        end
        S_UNIQ: begin
          // cancel_id serves as the slot counter during the id search
          if (ent_id[cancel_id[IDX_W-1:0]] == cand) begin
            cand      <= cand_inc;
            cancel_id <= '0;
          end else if (cancel_id[IDX_W-1:0] == IDX_LAST) begin
            for (int k = 1; k < TABLE_DEPTH; k++) begin
              if (IDX_W'(k) > idx) begin
                ent_id[k]     <= ent_id[k-1];
                ent_key[k]    <= ent_key[k-1];
                ent_due[k]    <= ent_due[k-1];
                ent_period[k] <= ent_period[k-1];
              end
            end
            ent_id[idx]     <= cand;
            ent_key[idx]    <= new_key;
            ent_due[idx]    <= new_due;
            ent_period[idx] <= new_per;
            o_valid <= 1'b1;
            o_kind  <= sstq_pkg::KIND_REG;
            o_id    <= cand;
            o_found <= 1'b0;
            o_key   <= '0;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end else begin
            cancel_id <= cancel_id + sstq_pkg::ID_W'(1);
          end
        end
        S_CANCEL: begin
          if (ent_id[idx] == cancel_id) begin
            for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
              if (IDX_W'(k) >= idx) begin
                ent_id[k]     <= ent_id[k+1];
                ent_key[k]    <= ent_key[k+1];
                ent_due[k]    <= ent_due[k+1];
                ent_period[k] <= ent_period[k+1];
              end
            end
            ent_id[TABLE_DEPTH-1] <= '0;
            o_valid <= 1'b1;
            o_kind  <= sstq_pkg::KIND_CANCEL;
            o_id    <= cancel_id;
            o_found <= 1'b1;
            o_key   <= '0;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end else if (idx == IDX_LAST) begin
            o_valid <= 1'b1;
            o_kind  <= sstq_pkg::KIND_CANCEL;
            o_id    <= cancel_id;
            o_found <= 1'b0;
            o_key   <= '0;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_FIRE: begin
          cand     <= ent_id[0];
          new_key  <= ent_key[0];
          new_per  <= ent_period[0];
          new_due  <= ent_due[0] + {1'b0, ent_period[0]};
          fire_cnt <= fire_cnt + CNT_W'(1);
          have_cur <= 1'b1;
          for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
            ent_id[k]     <= ent_id[k+1];
            ent_key[k]    <= ent_key[k+1];
            ent_due[k]    <= ent_due[k+1];
            ent_period[k] <= ent_period[k+1];
          end
          ent_id[TABLE_DEPTH-1] <= '0;
          idx   <= '0;
          state <= (ent_period[0] != '0) ? S_REINS : S_CHECK;
        end
        S_REINS: begin
          if (idx != IDX_LAST && ent_id[idx] != '0 &&
              !sstq_pkg::not_before(ent_due[idx], new_due)) begin
            idx <= idx + IDX_W'(1);
          end else begin
            for (int k = 1; k < TABLE_DEPTH; k++) begin
              if (IDX_W'(k) > idx) begin
                ent_id[k]     <= ent_id[k-1];
                ent_key[k]    <= ent_key[k-1];
                ent_due[k]    <= ent_due[k-1];
                ent_period[k] <= ent_period[k-1];
              end
            end
            ent_id[idx]     <= cand;
            ent_key[idx]    <= new_key;
            ent_due[idx]    <= new_due;
            ent_period[idx] <= new_per;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (have_cur) begin
            o_valid  <= 1'b1;
            o_kind   <= sstq_pkg::KIND_FIRE;
            o_id     <= cand;
            o_found  <= 1'b0;
            o_key    <= new_key;
            o_last   <= !cont;
            have_cur <= 1'b0;
            state    <= cont ? S_WAIT : S_IDLE;
          end else begin
            state <= cont ? S_FIRE : S_IDLE;
          end
        end
        S_WAIT: begin
          if (!o_valid) begin
            state <= S_FIRE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
